/* src/sabc_pkg.sv */
package sabc_pkg;

    localparam int SET_BITS    = 4;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 3;
    localparam int ADDR_BITS   = 12;

    localparam int TAG_BITS   = ADDR_BITS - SET_BITS - OFFSET_BITS;
    localparam int SETS       = 1 << SET_BITS;
    localparam int LINE_BYTES = 1 << OFFSET_BITS;
    localparam int WAY_BITS   = $clog2(WAYS);
    localparam int RANK_W     = $clog2(WAYS + 1);
    localparam int AGE_W      = 16;
    localparam int CNT_W      = $clog2(LINE_BYTES + 1);
    localparam int DATA_AW    = SET_BITS + WAY_BITS + OFFSET_BITS;
    localparam int DATA_WORDS = 1 << DATA_AW;
    localparam int MEM_WORDS  = 1 << ADDR_BITS;
    localparam int BYTE_W     = 8;
    localparam int WAY_OUT_W  = 2;

    localparam int S_TDATA_W = ((ADDR_BITS + BYTE_W + 7) / 8) * 8;
    localparam int M_FIELD_W = BYTE_W + 1 + WAY_OUT_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic MODE_AGE  = 1'b0;
    localparam logic MODE_RANK = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SPILL,
        ST_FILL,
        ST_ACCESS,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic look;
        logic spill;
        logic fill;
        logic access;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hit;
        logic evict;
        logic cnt_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [WAYS-1:0][TAG_BITS-1:0] tag;
        logic [WAYS-1:0][RANK_W-1:0]   rank;
        logic [WAYS-1:0][AGE_W-1:0]    age;
    } t_meta_row;

    localparam int META_W = $bits(t_meta_row);

endpackage

/* src/set_assoc_byte_cache.sv */
// Byte-wide 4-way set-associative write-back cache with its own 4 KiB backing
// store. Each input beat is one byte access (tuser = 1 read, 0 write); each
// produces exactly one output beat with the byte read (zero on writes), the
// hit flag, the way used, and whether a valid line was written back. A miss
// fills the first invalid way, else evicts the oldest way (mode 0) or the
// first way of rank one (mode 1, way 0 if none). Only reads age and rank
// ways. After reset the backing store is swept to zero, one byte per cycle;
// no beat is taken until the sweep ends, while configuration writes are taken
// at any time. A hit passes through the lookup, access and finish states; a
// miss first fills the 8-byte line in over the byte memories, one byte at a
// time, and an eviction before that moves the old line out. A new beat is
// taken only once the previous item has finished. The result sits in an
// output register, so the next beat is taken while the previous result waits;
// an item only stalls at its last step when the output register is still full.
module set_assoc_byte_cache (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sabc_pkg::S_TDATA_W-1:0]  i_s_tdata,  // address[11:0], write_byte[19:12]
    input  logic                            i_s_tuser,  // op
    // master side
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sabc_pkg::M_TDATA_W-1:0]  o_m_tdata,  // read_byte[7:0], hit[8],
                                                        // way_used[10:9], evicted[11]
    // configuration: replacement_mode
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data
);
    import sabc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Registers always writable; user must change the mode only while idle (unchecked).
    assign o_cfg_ready = 1'b1;

    sabc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_s_tready)
    );

    sabc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data)
    );

    // Hold off input beats while the backing store sweep runs.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !o_s_tready)
        else $error("input ready during backing store clear");

    // A lookup hit goes straight to the byte access.
    a_hit_to_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.look && status.hit) |=> cmd.access)
        else $error("hit did not advance to access");

    // A finished write-back always moves on to the line fill.
    a_spill_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.spill && status.cnt_last) |=> (cmd.fill && !status.cnt_last))
        else $error("write-back did not advance to fill");

    // Completing an access with room in the output register presents a result.
    a_finish_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish && status.out_free) |=> o_m_tvalid)
        else $error("finished access produced no result");

endmodule

/* src/sabc_ram.sv */
module sabc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/sabc_ctrl.sv */
module sabc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sabc_pkg::t_status i_status,
    output sabc_pkg::t_cmd    o_cmd,
    output logic              o_in_ready
);
    import sabc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.clr_done) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_LOOK;
            ST_LOOK: begin
                if (i_status.hit) begin
                    n_state = ST_ACCESS;
                end else if (i_status.evict) begin
                    n_state = ST_SPILL;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_SPILL:  if (i_status.cnt_last) n_state = ST_FILL;
            ST_FILL:   if (i_status.cnt_last) n_state = ST_ACCESS;
            ST_ACCESS: n_state = ST_FINISH;
            ST_FINISH: if (i_status.out_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_LOOK:   o_cmd.look   = 1'b1;
            ST_SPILL:  o_cmd.spill  = 1'b1;
            ST_FILL:   o_cmd.fill   = 1'b1;
            ST_ACCESS: o_cmd.access = 1'b1;
            ST_FINISH: o_cmd.finish = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

endmodule

/* src/sabc_dp.sv */
module sabc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sabc_pkg::t_cmd                  i_cmd,
    output sabc_pkg::t_status               o_status,
    input  logic                            i_s_tuser,
    input  logic [sabc_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sabc_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_data
);
    import sabc_pkg::*;

    logic                     r_mode;
    logic                     r_op;
    logic [TAG_BITS-1:0]      r_tag;
    logic [SET_BITS-1:0]      r_set;
    logic [OFFSET_BITS-1:0]   r_off;
    logic [BYTE_W-1:0]        r_wbyte;
    logic [SETS-1:0][WAYS-1:0] r_valid;
    logic [SETS-1:0]          r_init;
    t_meta_row                r_row;
    logic [WAY_BITS-1:0]      r_way;
    logic                     r_hit;
    logic                     r_evict;
    logic [CNT_W-1:0]         r_cnt;
    logic [ADDR_BITS-1:0]     r_clr;
    logic                     r_o_valid;
    logic [BYTE_W-1:0]        r_o_byte;
    logic                     r_o_hit;
    logic [WAY_OUT_W-1:0]     r_o_way;
    logic                     r_o_evict;

    logic [ADDR_BITS-1:0]     in_addr;
    logic [SET_BITS-1:0]      in_set;
    t_meta_row                meta_rd;
    t_meta_row                row;
    t_meta_row                n_row;
    logic [WAYS-1:0]          vrow;
    logic [WAYS-1:0]          veff;
    logic                     l_hit;
    logic [WAY_BITS-1:0]      l_hway;
    logic                     l_free;
    logic [WAY_BITS-1:0]      l_fway;
    logic                     l_r1;
    logic [WAY_BITS-1:0]      l_r1way;
    logic [AGE_W-1:0]         l_oldest;
    logic [WAY_BITS-1:0]      l_away;
    logic [WAY_BITS-1:0]      l_way;
    logic [RANK_W-1:0]        own_rank;
    logic [CNT_W-1:0]         cnt_m1;
    logic                     out_free;
    logic [BYTE_W-1:0]        data_rd;
    logic [BYTE_W-1:0]        back_rd;
    logic                     data_we;
    logic [DATA_AW-1:0]       data_wa;
    logic [BYTE_W-1:0]        data_wd;
    logic [DATA_AW-1:0]       data_ra;
    logic                     back_we;
    logic [ADDR_BITS-1:0]     back_wa;
    logic [BYTE_W-1:0]        back_wd;
    logic [ADDR_BITS-1:0]     back_ra;

    assign in_addr = i_s_tdata[ADDR_BITS-1:0];
    assign in_set  = in_addr[OFFSET_BITS +: SET_BITS];
    assign cnt_m1  = r_cnt - CNT_W'(1);
    assign out_free = !r_o_valid || i_m_tready;

    // Set lookup: hit, first free way, victim by rank or by age.
    always_comb begin
        row = meta_rd;
        if (!r_init[r_set]) begin
            row.rank = '0;
            row.age  = '0;
        end
        vrow     = r_valid[r_set];
        l_hit    = 1'b0;
        l_hway   = '0;
        l_free   = 1'b0;
        l_fway   = '0;
        l_r1     = 1'b0;
        l_r1way  = '0;
        l_oldest = row.age[0];
        l_away   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!l_hit && vrow[w] && row.tag[w] == r_tag) begin
                l_hit  = 1'b1;
                l_hway = WAY_BITS'(w);
            end
            if (!l_free && !vrow[w]) begin
                l_free = 1'b1;
                l_fway = WAY_BITS'(w);
            end
            if (!l_r1 && row.rank[w] == RANK_W'(1)) begin
                l_r1    = 1'b1;
                l_r1way = WAY_BITS'(w);
            end
        end
        for (int w = 1; w < WAYS; w++) begin
            if (row.age[w] > l_oldest) begin
                l_oldest = row.age[w];
                l_away   = WAY_BITS'(w);
            end
        end
        if (l_hit) begin
            l_way = l_hway;
        end else if (l_free) begin
            l_way = l_fway;
        end else if (r_mode == MODE_RANK) begin
            l_way = l_r1way;
        end else begin
            l_way = l_away;
        end
    end

    // Metadata row written back when the access completes.
    always_comb begin
        veff     = r_valid[r_set] | (WAYS'(1) << r_way);
        own_rank = r_row.rank[r_way];
        n_row    = r_row;
        n_row.tag[r_way] = r_tag;
        if (r_op == OP_READ) begin
            for (int w = 0; w < WAYS; w++) begin
                if (veff[w]) begin
                    if (r_row.rank[w] > own_rank) begin
                        n_row.rank[w] = r_row.rank[w] - RANK_W'(1);
                    end
                    if (WAY_BITS'(w) != r_way && r_row.age[w] < AGE_MAX) begin
                        n_row.age[w] = r_row.age[w] + AGE_W'(1);
                    end
                end
            end
            n_row.rank[r_way] = RANK_W'(WAYS);
            n_row.age[r_way]  = '0;
        end
    end

    always_comb begin
        data_ra = {r_set, r_way, r_off};
        if (i_cmd.spill) begin
            data_ra = {r_set, r_way, r_cnt[OFFSET_BITS-1:0]};
        end
        data_we = 1'b0;
        data_wa = {r_set, r_way, r_off};
        data_wd = r_wbyte;
        if (i_cmd.fill) begin
            data_we = (r_cnt != '0);
            data_wa = {r_set, r_way, cnt_m1[OFFSET_BITS-1:0]};
            data_wd = back_rd;
        end else if (i_cmd.access) begin
            data_we = (r_op == OP_WRITE);
        end
        back_ra = {r_tag, r_set, r_cnt[OFFSET_BITS-1:0]};
        back_we = 1'b0;
        back_wa = {r_row.tag[r_way], r_set, cnt_m1[OFFSET_BITS-1:0]};
        back_wd = data_rd;
        if (i_cmd.clear) begin
            back_we = 1'b1;
            back_wa = r_clr;
            back_wd = '0;
        end else if (i_cmd.spill) begin
            back_we = (r_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_AGE;
            r_valid   <= '0;
            r_init    <= '0;
            r_cnt     <= '0;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + ADDR_BITS'(1);
            end
            if (i_cmd.spill || i_cmd.fill) begin
                r_cnt <= o_status.cnt_last ? '0 : r_cnt + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                r_valid[r_set] <= veff;
                r_init[r_set]  <= 1'b1;
            end
            if (i_cmd.finish && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_s_tuser;
            r_tag   <= in_addr[ADDR_BITS-1 -: TAG_BITS];
            r_set   <= in_set;
            r_off   <= in_addr[OFFSET_BITS-1:0];
            r_wbyte <= i_s_tdata[ADDR_BITS +: BYTE_W];
        end
        if (i_cmd.look) begin
            r_row   <= row;
            r_way   <= l_way;
            r_hit   <= l_hit;
            r_evict <= !l_hit && !l_free;
        end
        if (i_cmd.finish && out_free) begin
            r_o_byte  <= (r_op == OP_READ) ? data_rd : '0;
            r_o_hit   <= r_hit;
            r_o_way   <= WAY_OUT_W'(r_way);
            r_o_evict <= r_evict;
        end
    end

    sabc_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.finish),
        .i_wr_addr (r_set),
        .i_wr_data (n_row),
        .i_rd_addr (i_cmd.accept ? in_set : r_set),
        .o_rd_data (meta_rd)
    );

    sabc_ram #(.WIDTH(BYTE_W), .DEPTH(DATA_WORDS)) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (data_we),
        .i_wr_addr (data_wa),
        .i_wr_data (data_wd),
        .i_rd_addr (data_ra),
        .o_rd_data (data_rd)
    );

    sabc_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_WORDS)) u_back_ram (
        .i_clk     (i_clk),
        .i_wr_en   (back_we),
        .i_wr_addr (back_wa),
        .i_wr_data (back_wd),
        .i_rd_addr (back_ra),
        .o_rd_data (back_rd)
    );

    assign o_status.clr_done = (r_clr == {ADDR_BITS{1'b1}});
    assign o_status.hit      = l_hit;
    assign o_status.evict    = !l_hit && !l_free;
    assign o_status.cnt_last = (r_cnt == CNT_W'(LINE_BYTES));
    assign o_status.out_free = out_free;

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}},
                         r_o_evict, r_o_way, r_o_hit, r_o_byte};

endmodule
